// ===== rtl/core/multi_button_debounce_events_macros.svh =====
// Assertion macros used by the debounce block's top-level RTL file.
`ifndef MULTI_BUTTON_DEBOUNCE_EVENTS_MACROS_SVH
`define MULTI_BUTTON_DEBOUNCE_EVENTS_MACROS_SVH

`ifndef SYNTH

// Checked on every rising clock edge, suspended while reset is high.
`define MBDE_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("mbde assertion failed");

// Checked on every rising clock edge, reset included.
`define MBDE_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("mbde assertion failed");

`else

`define MBDE_ASSERT(label, clk, rst, prop)
`define MBDE_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ===== rtl/core/mbde_pkg.sv =====
// Package with the shared types and constants of the button debounce block.
`default_nettype none

package mbde_pkg;

   // Default number of buttons handled by one block.
   localparam int BUTTONS_DEFAULT = 4;

   // Field widths of the request and of the configuration register.
   localparam int TIME_WIDTH     = 32;
   localparam int DEBOUNCE_WIDTH = 16;

   // Debounce time after reset, in milliseconds.
   localparam logic [DEBOUNCE_WIDTH-1:0] DEBOUNCE_RESET = 16'd40;

   // Event codes reported per button.
   typedef enum logic [1:0] {
      EV_NONE     = 2'd0,
      EV_PRESSED  = 2'd1,
      EV_RELEASED = 2'd2,
      EV_CLICK    = 2'd3
   } event_type;

   // Per-button result handed from a button slice to the top level.
   typedef struct packed {
      event_type event_code;
      logic      down;
   } button_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/multi_button_debounce_events.sv =====
// Top level of the multi-button debouncer with per-button event codes.
//
// Usage:
//   Each request on the req_ channel is one poll: a millisecond timestamp and
//   the raw pin levels of all buttons (1 high/released, 0 low/pressed).
//   Every request produces exactly one response on the rsp_ channel with a
//   two-bit event code per button and the mask of buttons held down.
//   The csr_ channel writes the debounce time in milliseconds; it is always
//   ready and should only be written while no poll is in flight.
//   A poll passes through the input register and then the button slices,
//   whose result is registered in the response buffer. Throughput is one
//   poll per cycle while the response buffer has room, set by the compare
//   and update in each button slice. Reset releases all buttons, clears
//   events and timers and restores the debounce time to 40 ms. When the
//   receiver stalls, the two-entry response buffer fills and then req_tready
//   drops until a response is taken.
`default_nettype none

module multi_button_debounce_events #(
   parameter int BUTTONS = mbde_pkg::BUTTONS_DEFAULT
) (
   input  wire logic                                         clock,
   input  wire logic                                         reset,
   // Request: [31:0] now_ms, [32+BUTTONS-1:32] raw_levels, zero padded.
   input  wire logic                                         req_tvalid,
   output logic                                              req_tready,
   input  wire logic [((mbde_pkg::TIME_WIDTH+BUTTONS+7)/8)*8-1:0] req_tdata,
   // Response: [2*BUTTONS-1:0] event_codes, [3*BUTTONS-1:2*BUTTONS] down_mask,
   // zero padded.
   output logic                                              rsp_tvalid,
   input  wire logic                                         rsp_tready,
   output logic [((3*BUTTONS+7)/8)*8-1:0]                     rsp_tdata,
   // Debounce time register write.
   input  wire logic                                         csr_valid,
   output logic                                              csr_ready,
   input  wire logic [mbde_pkg::DEBOUNCE_WIDTH-1:0]          csr_data
);

`include "multi_button_debounce_events_macros.svh"

   localparam int RSP_WIDTH = ((3*BUTTONS+7)/8)*8;
   localparam int RES_WIDTH = 3*BUTTONS;

   logic                                   in_valid_ff;
   logic                                   in_valid_in;
   logic [mbde_pkg::TIME_WIDTH-1:0]        in_now_ff;
   logic [BUTTONS-1:0]                     in_raw_ff;
   logic [mbde_pkg::DEBOUNCE_WIDTH-1:0]    debounce_ff;
   logic                                   req_accept;
   logic                                   fire;
   logic                                   q_full;
   logic                                   rsp_pop;
   logic [RES_WIDTH-1:0]                   q_data;
   logic [2*BUTTONS-1:0]                   events;
   logic [BUTTONS-1:0]                     down;
   logic [BUTTONS-1:0]                     rsp_pressed;
   logic [BUTTONS-1:0]                     rsp_click;
   logic [BUTTONS-1:0]                     rsp_released;
   mbde_pkg::button_status_type            status [BUTTONS];

   // Configuration register, always ready.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= mbde_pkg::DEBOUNCE_RESET;
      end else if (csr_valid) begin
         debounce_ff <= csr_data;
      end
   end

   // Input register: a poll moves on when the response buffer has room.
   assign fire       = in_valid_ff && !q_full;
   assign req_tready = !in_valid_ff || !q_full;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_now_ff <= req_tdata[mbde_pkg::TIME_WIDTH-1:0];
         in_raw_ff <= req_tdata[mbde_pkg::TIME_WIDTH +: BUTTONS];
      end
   end

   // One slice per button, all evaluated in the same cycle.
   for (genvar i = 0; i < BUTTONS; i++) begin : g_button
      mbde_button u_button (
         .clock       (clock),
         .reset       (reset),
         .fire        (fire),
         .now_ms      (in_now_ff),
         .raw_level   (in_raw_ff[i]),
         .settle_ms   (debounce_ff),
         .status      (status[i])
      );

      assign events[2*i +: 2] = status[i].event_code;
      assign down[i]          = status[i].down;

      // Per-button decode of the response, used by the checks below.
      assign rsp_pressed[i]  = q_data[2*i +: 2] == mbde_pkg::EV_PRESSED;
      assign rsp_click[i]    = q_data[2*i +: 2] == mbde_pkg::EV_CLICK;
      assign rsp_released[i] = q_data[2*i +: 2] == mbde_pkg::EV_RELEASED;
   end

   // Response buffer.
   assign rsp_pop = rsp_tvalid && rsp_tready;

   mbde_rsp_queue #(
      .WIDTH (RES_WIDTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fire),
      .push_data ({down, events}),
      .pop       (rsp_pop),
      .full      (q_full),
      .valid     (rsp_tvalid),
      .data      (q_data)
   );

   assign rsp_tdata = RSP_WIDTH'(q_data);

   // A processed poll is visible as a response on the next cycle.
   `MBDE_ASSERT(a_fire_gives_rsp, clock, reset, fire |=> rsp_tvalid)

   // A press event always comes with the button held down.
   `MBDE_ASSERT(a_pressed_is_down, clock, reset,
      rsp_tvalid |-> ((rsp_pressed & ~q_data[2*BUTTONS +: BUTTONS]) == '0))

   // A click event always comes with the button released.
   `MBDE_ASSERT(a_click_is_up, clock, reset,
      rsp_tvalid |-> ((rsp_click & q_data[2*BUTTONS +: BUTTONS]) == '0))

   // The released code is never reported.
   `MBDE_ASSERT(a_no_released, clock, reset, rsp_tvalid |-> (rsp_released == '0))

   // No poll is left waiting while the response buffer has room.
   `MBDE_ASSERT_ALWAYS(a_ready_when_room, clock, !q_full |-> req_tready)

endmodule

`default_nettype wire

// ===== rtl/core/mbde_button.sv =====
// One button slice: raw level tracking, settle timer compare and event state.
`default_nettype none

module mbde_button (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 fire,
   input  wire logic [mbde_pkg::TIME_WIDTH-1:0]      now_ms,
   input  wire logic                                 raw_level,
   input  wire logic [mbde_pkg::DEBOUNCE_WIDTH-1:0]  settle_ms,
   output mbde_pkg::button_status_type               status
);

   logic                                raw_seen_ff;
   logic                                raw_seen_in;
   logic                                stable_ff;
   logic                                stable_in;
   logic [mbde_pkg::TIME_WIDTH-1:0]     change_time_ff;
   logic [mbde_pkg::TIME_WIDTH-1:0]     change_time_in;
   mbde_pkg::event_type                 held_event_ff;
   mbde_pkg::event_type                 held_event_in;
   logic [mbde_pkg::TIME_WIDTH-1:0]     elapsed;
   logic                                settled;

   // A raw edge restarts the settle timer at the poll time.
   always_comb begin
      raw_seen_in    = raw_level;
      change_time_in = (raw_level != raw_seen_ff) ? now_ms : change_time_ff;
      elapsed        = now_ms - change_time_in;
      settled        = elapsed >= mbde_pkg::TIME_WIDTH'(settle_ms);
   end

   // Once settled, the debounced level follows raw and the event is refreshed.
   always_comb begin
      stable_in     = stable_ff;
      held_event_in = held_event_ff;
      if (settled) begin
         if (stable_ff != raw_level) begin
            stable_in     = raw_level;
            held_event_in = raw_level ? mbde_pkg::EV_CLICK : mbde_pkg::EV_PRESSED;
         end else begin
            held_event_in = mbde_pkg::EV_NONE;
         end
      end
   end

   // State advances only when a poll is processed.
   always_ff @(posedge clock) begin
      if (reset) begin
         raw_seen_ff    <= 1'b1;
         stable_ff      <= 1'b1;
         change_time_ff <= '0;
         held_event_ff  <= mbde_pkg::EV_NONE;
      end else if (fire) begin
         raw_seen_ff    <= raw_seen_in;
         stable_ff      <= stable_in;
         change_time_ff <= change_time_in;
         held_event_ff  <= held_event_in;
      end
   end

   // Result of the poll being processed this cycle.
   assign status.event_code = held_event_in;
   assign status.down       = ~stable_in;

endmodule

`default_nettype wire

// ===== rtl/core/mbde_rsp_queue.sv =====
// Two-entry result buffer that decouples the processing stage from a stalled receiver.
`default_nettype none

module mbde_rsp_queue #(
   parameter int WIDTH = 12
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic                  full,
   output logic                  valid,
   output logic [WIDTH-1:0]      data
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff;
   logic             wr_ptr_in;
   logic             rd_ptr_ff;
   logic             rd_ptr_in;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full  = count_ff == 2'd2;
   assign valid = count_ff != 2'd0;
   assign data  = entry_ff[rd_ptr_ff];

endmodule

`default_nettype wire
